// ===== rtl/nnsb_pkg.sv =====
// ----------------------------------------------------------------------------
// nnsb_pkg
// shared types and constants for the nearest-neighbour scaled blit address
// generator: config record, pixel job record, register map, back-end states
// ----------------------------------------------------------------------------
package nnsb_pkg;

    // default destination surface size
    localparam int SURF_W_DEF = 1024;
    localparam int SURF_H_DEF = 1024;

    // field widths
    localparam int COORD_W    = 12;   // surface coordinate, surface up to 4096
    localparam int SIZE_W     = 12;   // rectangle sizes and source offsets
    localparam int OFF_W      = 14;   // signed destination offsets
    localparam int DIST_W     = 15;   // signed distance from destination edge
    localparam int MAG_W      = 14;   // magnitude of that distance
    localparam int PROD_W     = MAG_W + SIZE_W;
    localparam int OUT_DST_W  = 10;
    localparam int OUT_SRC_W  = 13;

    // stream and register port widths
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 48;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // job queue between front and back
    localparam int Q_DEPTH    = 2;

    typedef enum logic [2:0] {
        REG_SRC_LEFT,
        REG_SRC_TOP,
        REG_SRC_WIDTH,
        REG_SRC_HEIGHT,
        REG_DST_LEFT,
        REG_DST_TOP,
        REG_DST_WIDTH,
        REG_DST_HEIGHT
    } t_reg_idx;

    typedef struct packed {
        logic        [SIZE_W-1:0] src_left;
        logic        [SIZE_W-1:0] src_top;
        logic        [SIZE_W-1:0] src_width;
        logic        [SIZE_W-1:0] src_height;
        logic signed [OFF_W-1:0]  dst_left;
        logic signed [OFF_W-1:0]  dst_top;
        logic        [SIZE_W-1:0] dst_width;
        logic        [SIZE_W-1:0] dst_height;
    } t_cfg;

    // one visible destination pixel
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_job;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        t_job job;
    } t_q_head;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_HOLD
    } t_back_state;

endpackage

// ===== rtl/nnsb_div.sv =====
// ----------------------------------------------------------------------------
// nnsb_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module nnsb_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [nnsb_pkg::PROD_W-1:0] i_dividend,
    input  logic [nnsb_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [nnsb_pkg::PROD_W-1:0] o_quotient
);
    import nnsb_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_div, n_div;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;

    always_comb begin
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        shifted = {r_rem, r_quo[PROD_W-1]};
        diff    = shifted - {1'b0, r_div};
        if (i_start) begin
            n_cnt = CNT_W'(PROD_W);
            n_quo = i_dividend;
            n_rem = '0;
            n_div = i_divisor;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_W'(1);
            // keep the subtraction when it did not borrow
            if (!diff[SIZE_W]) begin
                n_rem = diff[SIZE_W-1:0];
                n_quo = {r_quo[PROD_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[SIZE_W-1:0];
                n_quo = {r_quo[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

endmodule

// ===== rtl/nnsb_front.sv =====
// ----------------------------------------------------------------------------
// nnsb_front
// takes request beats, clips the destination rectangle and walks the
// visible pixels in row-major order, one job per pixel
// ----------------------------------------------------------------------------
module nnsb_front #(
    parameter int DEST_WIDTH  = nnsb_pkg::SURF_W_DEF,
    parameter int DEST_HEIGHT = nnsb_pkg::SURF_H_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nnsb_pkg::t_cfg i_cfg,
    input  logic           i_valid,
    input  logic           i_begin,
    output logic           o_ready,
    input  logic           i_q_full,
    output logic           o_push,
    output nnsb_pkg::t_job o_job
);
    import nnsb_pkg::*;

    localparam int CW = (DEST_WIDTH  > 1) ? $clog2(DEST_WIDTH)  : 1;
    localparam int RW = (DEST_HEIGHT > 1) ? $clog2(DEST_HEIGHT) : 1;
    localparam logic signed [DIST_W-1:0] SURF_W = DIST_W'(DEST_WIDTH);
    localparam logic signed [DIST_W-1:0] SURF_H = DIST_W'(DEST_HEIGHT);

    logic          r_busy, n_busy;
    logic [CW-1:0] r_col, n_col, r_cs, n_cs, r_ce, n_ce;
    logic [RW-1:0] r_row, n_row, r_re, n_re;

    logic                     sizes_ok, accept, go, last;
    logic signed [DIST_W-1:0] x0, y0, x1_raw, y1_raw, x1, y1, x1m, y1m;
    logic [CW-1:0]            p_col, p_cs, p_ce;
    logic [RW-1:0]            p_row, p_re;

    assign sizes_ok = (i_cfg.src_width != '0) && (i_cfg.src_height != '0) &&
                      (i_cfg.dst_width != '0) && (i_cfg.dst_height != '0);

    // clipped bounds, upper end exclusive
    always_comb begin
        x0     = (i_cfg.dst_left > 0) ? DIST_W'(i_cfg.dst_left) : '0;
        y0     = (i_cfg.dst_top  > 0) ? DIST_W'(i_cfg.dst_top)  : '0;
        x1_raw = DIST_W'(i_cfg.dst_left) +
                 $signed({{(DIST_W-SIZE_W){1'b0}}, i_cfg.dst_width});
        y1_raw = DIST_W'(i_cfg.dst_top) +
                 $signed({{(DIST_W-SIZE_W){1'b0}}, i_cfg.dst_height});
        x1     = (x1_raw > SURF_W) ? SURF_W : x1_raw;
        y1     = (y1_raw > SURF_H) ? SURF_H : y1_raw;
        x1m    = x1 - DIST_W'(1);
        y1m    = y1 - DIST_W'(1);
    end

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (i_begin) begin
            go    = sizes_ok && (x0 < x1) && (y0 < y1);
            p_col = x0[CW-1:0];
            p_row = y0[RW-1:0];
            p_cs  = x0[CW-1:0];
            p_ce  = x1m[CW-1:0];
            p_re  = y1m[RW-1:0];
        end else begin
            go    = r_busy && sizes_ok;
            p_col = r_col;
            p_row = r_row;
            p_cs  = r_cs;
            p_ce  = r_ce;
            p_re  = r_re;
        end
        last = (p_col >= p_ce) && (p_row >= p_re);

        n_busy = r_busy;
        n_col  = r_col;
        n_row  = r_row;
        n_cs   = r_cs;
        n_ce   = r_ce;
        n_re   = r_re;
        o_push = 1'b0;
        if (accept) begin
            n_busy = go && !last;
            if (go) begin
                o_push = 1'b1;
                n_cs   = p_cs;
                n_ce   = p_ce;
                n_re   = p_re;
                if (p_col >= p_ce) begin
                    n_col = p_cs;
                    n_row = p_row + RW'(1);
                end else begin
                    n_col = p_col + CW'(1);
                    n_row = p_row;
                end
            end
        end

        o_job.col  = COORD_W'(p_col);
        o_job.row  = COORD_W'(p_row);
        o_job.last = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_col  <= '0;
            r_row  <= '0;
            r_cs   <= '0;
            r_ce   <= '0;
            r_re   <= '0;
        end else begin
            r_busy <= n_busy;
            r_col  <= n_col;
            r_row  <= n_row;
            r_cs   <= n_cs;
            r_ce   <= n_ce;
            r_re   <= n_re;
        end
    end

endmodule

// ===== rtl/nnsb_queue.sv =====
// ----------------------------------------------------------------------------
// nnsb_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module nnsb_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  nnsb_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output nnsb_pkg::t_q_head o_head
);
    import nnsb_pkg::*;

    localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_job            r_mem [Q_DEPTH];
    logic [QA_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QC_W-1:0] r_cnt, n_cnt;
    logic            do_push, do_pop;

    assign o_full       = (r_cnt == QC_W'(Q_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QA_W'(Q_DEPTH - 1)) ? '0 : r_wr + QA_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == QA_W'(Q_DEPTH - 1)) ? '0 : r_rd + QA_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + QC_W'(1);
            2'b01:   n_cnt = r_cnt - QC_W'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/nnsb_back.sv =====
// ----------------------------------------------------------------------------
// nnsb_back
// maps each pixel job to its source pixel: signed distance times source
// size, divided by destination size, added to the source offset
// ----------------------------------------------------------------------------
module nnsb_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nnsb_pkg::t_cfg                  i_cfg,
    input  nnsb_pkg::t_q_head               i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [nnsb_pkg::M_TDATA_W-1:0]  o_data,
    output logic                            o_last
);
    import nnsb_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job, n_job;
    logic        r_neg_x, n_neg_x, r_neg_y, n_neg_y;
    logic        r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0] r_out_data, n_out_data;
    logic        r_out_last, n_out_last;

    logic signed [DIST_W-1:0] dist_x, dist_y;
    logic [MAG_W-1:0]         mag_x, mag_y;
    logic [PROD_W-1:0]        prod_x, prod_y, quo_x, quo_y;
    logic                     div_start, busy_x, busy_y, load;
    logic [OUT_SRC_W-1:0]     src_x, src_y, q_x, q_y, base_x, base_y;

    // distance of the pixel from the destination edge, then its magnitude
    always_comb begin
        dist_x = $signed({{(DIST_W-COORD_W){1'b0}}, r_job.col}) - DIST_W'(i_cfg.dst_left);
        dist_y = $signed({{(DIST_W-COORD_W){1'b0}}, r_job.row}) - DIST_W'(i_cfg.dst_top);
        mag_x  = dist_x[DIST_W-1] ? MAG_W'(-dist_x) : MAG_W'(dist_x);
        mag_y  = dist_y[DIST_W-1] ? MAG_W'(-dist_y) : MAG_W'(dist_y);
        prod_x = PROD_W'(mag_x) * PROD_W'(i_cfg.src_width);
        prod_y = PROD_W'(mag_y) * PROD_W'(i_cfg.src_height);
    end

    nnsb_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_x),
        .i_divisor  (i_cfg.dst_width),
        .o_busy     (busy_x),
        .o_quotient (quo_x)
    );

    nnsb_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_y),
        .i_divisor  (i_cfg.dst_height),
        .o_busy     (busy_y),
        .o_quotient (quo_y)
    );

    // quotient truncated toward zero, result wraps to the output width
    always_comb begin
        q_x    = quo_x[OUT_SRC_W-1:0];
        q_y    = quo_y[OUT_SRC_W-1:0];
        base_x = OUT_SRC_W'(i_cfg.src_left);
        base_y = OUT_SRC_W'(i_cfg.src_top);
        src_x  = r_neg_x ? base_x - q_x : base_x + q_x;
        src_y  = r_neg_y ? base_y - q_y : base_y + q_y;
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_neg_x     = r_neg_x;
        n_neg_y     = r_neg_y;
        o_pop       = 1'b0;
        div_start   = 1'b0;
        load        = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_job   = i_head.job;
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                div_start = 1'b1;
                n_neg_x   = dist_x[DIST_W-1];
                n_neg_y   = dist_y[DIST_W-1];
                n_state   = BK_DIV;
            end
            BK_DIV: begin
                if (!busy_x && !busy_y) begin
                    n_state = BK_HOLD;
                end
            end
            BK_HOLD: begin
                if (!r_out_valid || i_ready) begin
                    load    = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase

        // output register
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        if (load) begin
            n_out_valid = 1'b1;
            n_out_data  = {2'b00, src_y, src_x,
                           r_job.row[OUT_DST_W-1:0], r_job.col[OUT_DST_W-1:0]};
            n_out_last  = r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_neg_x    <= n_neg_x;
        r_neg_y    <= n_neg_y;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

// ===== rtl/nearest_neighbor_scale_blit_addresses.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_blit_addresses
// address generator for a nearest-neighbour scaled copy: one copy command
// per visible destination pixel, row-major, last one flagged
// ----------------------------------------------------------------------------
//  channel    dir  handshake             payload
//  s_*        in   s_tvalid / s_tready   s_tdata[0] begin_req
//  m_*        out  m_tvalid / m_tready   m_tdata dst_x,dst_y,src_x,src_y; m_tlast
//  apb        in   psel,penable,pwrite   paddr (reg index * 4), pwdata, prdata
//
//  a request beat is taken whenever the job queue has room
//  each pixel passes through the back end in steps: queue pop, multiply,
//    26 restoring divider steps (one quotient bit per cycle), a done step
//    and the output load; a new pixel leaves the queue only after the last
//    one is loaded, so the divider sets the sustained rate
//  synchronous active-low reset clears config, cursor, queue and back end
//  m_tready low holds the output register; the back end finishes the next
//    pixel meanwhile and s_tready drops only once the two-entry queue fills
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_blit_addresses #(
    parameter int DEST_WIDTH  = nnsb_pkg::SURF_W_DEF,
    parameter int DEST_HEIGHT = nnsb_pkg::SURF_H_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nnsb_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] begin_req, rest zero
    // copy command stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nnsb_pkg::M_TDATA_W-1:0]    m_tdata,   // [9:0] out_dst_x,
                                                         // [19:10] out_dst_y,
                                                         // [32:20] out_src_x,
                                                         // [45:33] out_src_y, rest zero
    output logic                              m_tlast,   // last_pixel
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nnsb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nnsb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nnsb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import nnsb_pkg::*;

    t_cfg     r_cfg, n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    t_job     front_job;
    logic     front_push;
    logic     q_full;
    t_q_head  q_head;
    logic     back_pop;

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SRC_LEFT:   n_cfg.src_left   = pwdata[SIZE_W-1:0];
                REG_SRC_TOP:    n_cfg.src_top    = pwdata[SIZE_W-1:0];
                REG_SRC_WIDTH:  n_cfg.src_width  = pwdata[SIZE_W-1:0];
                REG_SRC_HEIGHT: n_cfg.src_height = pwdata[SIZE_W-1:0];
                REG_DST_LEFT:   n_cfg.dst_left   = $signed(pwdata[OFF_W-1:0]);
                REG_DST_TOP:    n_cfg.dst_top    = $signed(pwdata[OFF_W-1:0]);
                REG_DST_WIDTH:  n_cfg.dst_width  = pwdata[SIZE_W-1:0];
                REG_DST_HEIGHT: n_cfg.dst_height = pwdata[SIZE_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // read back, destination offsets sign extended
    always_comb begin
        unique case (reg_idx)
            REG_SRC_LEFT:   prdata = APB_DATA_W'(r_cfg.src_left);
            REG_SRC_TOP:    prdata = APB_DATA_W'(r_cfg.src_top);
            REG_SRC_WIDTH:  prdata = APB_DATA_W'(r_cfg.src_width);
            REG_SRC_HEIGHT: prdata = APB_DATA_W'(r_cfg.src_height);
            REG_DST_LEFT:   prdata = APB_DATA_W'(r_cfg.dst_left);
            REG_DST_TOP:    prdata = APB_DATA_W'(r_cfg.dst_top);
            REG_DST_WIDTH:  prdata = APB_DATA_W'(r_cfg.dst_width);
            REG_DST_HEIGHT: prdata = APB_DATA_W'(r_cfg.dst_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------- front: clip and walk pixels ----------------
    nnsb_front #(
        .DEST_WIDTH  (DEST_WIDTH),
        .DEST_HEIGHT (DEST_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_tvalid),
        .i_begin  (s_tdata[0]),
        .o_ready  (s_tready),
        .i_q_full (q_full),
        .o_push   (front_push),
        .o_job    (front_job)
    );

    // ---------------- job queue ----------------
    nnsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (back_pop),
        .o_head  (q_head)
    );

    // ---------------- back: source mapping and output register ----------------
    nnsb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (q_head),
        .o_pop   (back_pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_last  (m_tlast)
    );

endmodule

// ===== tb/nnsb_copy_checker.sv =====
// ----------------------------------------------------------------------------
// nnsb_copy_checker
// watches the request, command and register channels of the scaled blit
// address generator, predicts every copy command and compares it on arrival
// ----------------------------------------------------------------------------
module nnsb_copy_checker
    import nnsb_pkg::*;
#(
    parameter int DEST_WIDTH  = SURF_W_DEF,
    parameter int DEST_HEIGHT = SURF_H_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [0] begin_req
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [M_TDATA_W-1:0]  i_m_tdata,   // dst_x, dst_y, src_x, src_y
    input  logic                  i_m_tlast,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_copies,
    output int                    o_blits
);

    typedef struct packed {
        logic [OUT_DST_W-1:0] dst_x;
        logic [OUT_DST_W-1:0] dst_y;
        logic [OUT_SRC_W-1:0] src_x;
        logic [OUT_SRC_W-1:0] src_y;
        logic                 last;
    } t_copy_cmd;

    // register copy
    logic        [SIZE_W-1:0] src_left, src_top, src_width, src_height;
    logic signed [OFF_W-1:0]  dst_left, dst_top;
    logic        [SIZE_W-1:0] dst_width, dst_height;

    // blit cursor and latched clip bounds
    logic blit_active;
    int   cur_col, cur_row, clip_col_start, clip_col_end, clip_row_end;

    t_copy_cmd expected_copies[$];

    function automatic bit sizes_ok();
        return src_width != 0 && src_height != 0 && dst_width != 0 && dst_height != 0;
    endfunction

    // signed distance scaled, truncated toward zero, wrapped to the port width
    function automatic logic [OUT_SRC_W-1:0] scale_coord(input int pos, input int dst_off,
                                                        input int src_size, input int dst_size,
                                                        input int src_off);
        longint delta, quot, sum;
        delta = longint'(pos) - longint'(dst_off);
        quot  = (delta * longint'(src_size)) / longint'(dst_size);
        sum   = longint'(src_off) + quot;
        return sum[OUT_SRC_W-1:0];
    endfunction

    task automatic write_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
        case (t_reg_idx'(addr[4:2]))
            REG_SRC_LEFT:   src_left   = data[SIZE_W-1:0];
            REG_SRC_TOP:    src_top    = data[SIZE_W-1:0];
            REG_SRC_WIDTH:  src_width  = data[SIZE_W-1:0];
            REG_SRC_HEIGHT: src_height = data[SIZE_W-1:0];
            REG_DST_LEFT:   dst_left   = data[OFF_W-1:0];
            REG_DST_TOP:    dst_top    = data[OFF_W-1:0];
            REG_DST_WIDTH:  dst_width  = data[SIZE_W-1:0];
            REG_DST_HEIGHT: dst_height = data[SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_blit(input logic start);
        int        x0, y0, x1, y1;
        t_copy_cmd cmd;
        if (start) begin
            blit_active = 1'b0;
            if (!sizes_ok())
                return;
            x0 = (dst_left > 0) ? int'(dst_left) : 0;
            y0 = (dst_top > 0) ? int'(dst_top) : 0;
            x1 = int'(dst_left) + int'(dst_width);
            y1 = int'(dst_top) + int'(dst_height);
            if (x1 > DEST_WIDTH)
                x1 = DEST_WIDTH;
            if (y1 > DEST_HEIGHT)
                y1 = DEST_HEIGHT;
            if (x0 >= x1 || y0 >= y1)
                return;
            clip_col_start = x0;
            clip_col_end   = x1 - 1;
            clip_row_end   = y1 - 1;
            cur_col        = x0;
            cur_row        = y0;
            blit_active    = 1'b1;
        end else if (!blit_active) begin
            return;
        end
        // a size cleared mid-blit abandons it
        if (!sizes_ok()) begin
            blit_active = 1'b0;
            return;
        end
        cmd.dst_x = cur_col[OUT_DST_W-1:0];
        cmd.dst_y = cur_row[OUT_DST_W-1:0];
        cmd.src_x = scale_coord(cur_col, dst_left, src_width, dst_width, src_left);
        cmd.src_y = scale_coord(cur_row, dst_top, src_height, dst_height, src_top);
        cmd.last  = (cur_col >= clip_col_end) && (cur_row >= clip_row_end);
        expected_copies.push_back(cmd);
        if (cmd.last) begin
            blit_active = 1'b0;
        end else if (cur_col >= clip_col_end) begin
            cur_col = clip_col_start;
            cur_row++;
        end else begin
            cur_col++;
        end
    endtask

    task automatic report_copy(input string what, input t_copy_cmd want,
                               input t_copy_cmd got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("%0t: %s: expected dst %0d,%0d src %0d,%0d last %0b, %s",
                     $time, what, want.dst_x, want.dst_y, want.src_x, want.src_y,
                     want.last,
                     $sformatf("got dst %0d,%0d src %0d,%0d last %0b",
                               got.dst_x, got.dst_y, got.src_x, got.src_y, got.last));
    endtask

    always @(posedge i_clk) begin : watch
        t_copy_cmd got, want;
        if (!i_rst_n) begin
            {src_left, src_top, src_width, src_height} = '0;
            {dst_left, dst_top, dst_width, dst_height} = '0;
            blit_active    = 1'b0;
            cur_col        = 0;
            cur_row        = 0;
            clip_col_start = 0;
            clip_col_end   = 0;
            clip_row_end   = 0;
            o_mismatches   = 0;
            o_copies       = 0;
            o_blits        = 0;
            expected_copies.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_register(i_paddr, i_pwdata);
            if (i_s_tvalid && i_s_tready)
                advance_blit(i_s_tdata[0]);
            if (i_m_tvalid && i_m_tready) begin
                got.dst_x = i_m_tdata[9:0];
                got.dst_y = i_m_tdata[19:10];
                got.src_x = i_m_tdata[32:20];
                got.src_y = i_m_tdata[45:33];
                got.last  = i_m_tlast;
                if (expected_copies.size() == 0) begin
                    report_copy("unexpected copy beat", '0, got);
                end else begin
                    want = expected_copies.pop_front();
                    if (got.dst_x !== want.dst_x || got.dst_y !== want.dst_y ||
                        got.src_x !== want.src_x || got.src_y !== want.src_y ||
                        got.last !== want.last)
                        report_copy("copy command mismatch", want, got);
                    o_copies++;
                    if (want.last)
                        o_blits++;
                end
            end
        end
        o_pending = expected_copies.size();
    end

endmodule

// ===== tb/nearest_neighbor_scale_blit_addresses_test.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_blit_addresses_test
// drives begin and next-pixel requests into the scaled blit address generator
// under many rectangle settings and random stalls on both streams; a checker
// beside the block predicts every copy command and counts mismatches
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_blit_addresses_test;
    import nnsb_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 64;    // settle time after the last predicted command
    localparam int REQ_ITEMS     = 1900;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_RANDOM_PX = 48;    // keeps most random blits short

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;   // [0] begin_req
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // dst_x, dst_y, src_x, src_y
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches, pending, copies, blits;
    int cycles        = 0;
    int items_sent    = 0;
    int blit_items    = 0;
    int config_writes = 0;
    int tx_gap_max    = 0;
    int rx_gap_max    = 0;
    int rx_hold       = 0;

    // what the registers were last set to, for shaping the stimulus
    int shadow[8] = '{default: 0};

    always #5 i_clk = ~i_clk;

    nearest_neighbor_scale_blit_addresses dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    nnsb_copy_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_copies    (copies),
        .o_blits     (blits)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d copy command(s) still awaited",
                     cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // register write: setup cycle, access cycle, then psel drops before the next
    // write so that back-to-back writes never lower and raise psel in the same step
    task automatic write_reg(input t_reg_idx idx, input int value);
        shadow[idx] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        if (idx == REG_DST_LEFT || idx == REG_DST_TOP)
            pwdata <= value & 32'h3FFF;
        else
            pwdata <= value & 32'h0FFF;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        config_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_rect(input int sl, input int st, input int sw, input int sh,
                            input int dl, input int dt, input int dw, input int dh);
        write_reg(REG_SRC_LEFT, sl);
        write_reg(REG_SRC_TOP, st);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_LEFT, dl);
        write_reg(REG_DST_TOP, dt);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    // one request beat; tvalid stays high into the next beat when no gap is drawn
    task automatic send_req(input logic start);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, start};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // sender stops until every predicted command is out, then lets any
    // request with no result work through before registers are touched
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic int visible_pixels();
        int x0, y0, x1, y1;
        x0 = shadow[REG_DST_LEFT] > 0 ? shadow[REG_DST_LEFT] : 0;
        y0 = shadow[REG_DST_TOP] > 0 ? shadow[REG_DST_TOP] : 0;
        x1 = shadow[REG_DST_LEFT] + shadow[REG_DST_WIDTH];
        y1 = shadow[REG_DST_TOP] + shadow[REG_DST_HEIGHT];
        x1 = x1 > SURF_W_DEF ? SURF_W_DEF : x1;
        y1 = y1 > SURF_H_DEF ? SURF_H_DEF : y1;
        if (shadow[REG_SRC_WIDTH] == 0 || shadow[REG_SRC_HEIGHT] == 0)
            return 0;
        if (x1 <= x0 || y1 <= y0)
            return 0;
        return (x1 - x0) * (y1 - y0);
    endfunction

    function automatic int pick_idle_max();
        int p;
        p = $urandom_range(0, 3);
        return p == 0 ? 0 : (p == 1 ? int'($urandom_range(1, 12)) : 12);
    endfunction

    // register values biased toward the extremes and the surface edges
    function automatic int draw_value(input t_reg_idx idx);
        int pick, edge_pos;
        pick     = $urandom_range(0, 9);
        edge_pos = (idx == REG_DST_LEFT) ? SURF_W_DEF : SURF_H_DEF;
        case (idx)
            REG_SRC_LEFT, REG_SRC_TOP: begin
                if (pick == 0)
                    return 0;
                if (pick == 1)
                    return 4095;
                return $urandom_range(0, 4095);
            end
            REG_SRC_WIDTH, REG_SRC_HEIGHT: begin
                if (pick == 0)
                    return 0;
                if (pick == 1)
                    return 4095;
                if (pick < 4)
                    return $urandom_range(1, 4);
                return $urandom_range(1, 4095);
            end
            REG_DST_LEFT, REG_DST_TOP: begin
                case (pick)
                    0:       return -8192;
                    1:       return 8191;
                    2:       return int'($signed(14'($urandom())));
                    3, 4:    return edge_pos - int'($urandom_range(0, 12));
                    5, 6:    return int'($urandom_range(0, 16)) - 8;
                    default: return $urandom_range(0, 1000);
                endcase
            end
            default: begin
                if (pick == 0)
                    return 0;
                if (pick == 1)
                    return 4095;
                if (pick < 4)
                    return $urandom_range(7, 24);
                return $urandom_range(1, 6);
            end
        endcase
    endfunction

    task automatic random_config(input bit all_regs);
        for (int r = 0; r < 8; r++)
            if (all_regs || $urandom_range(0, 2) == 0)
                write_reg(t_reg_idx'(r), draw_value(t_reg_idx'(r)));
        // pull big visible areas back to a handful of pixels
        if (visible_pixels() > MAX_RANDOM_PX) begin
            write_reg(REG_DST_WIDTH, $urandom_range(0, 6));
            write_reg(REG_DST_HEIGHT, $urandom_range(0, 6));
        end
    endtask

    // mostly whole blits; some restarted, overrun, changed mid-way, or noise
    task automatic run_blit_sequence();
        int n, kind, k;
        n    = visible_pixels();
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            repeat ($urandom_range(1, 6)) send_req(1'($urandom_range(0, 1)));
        end else if (kind == 6 && n > 2) begin
            // registers rewritten while the blit is still open
            k = $urandom_range(0, n - 3);
            send_req(1'b1);
            repeat (k) send_req(1'b0);
            blit_items += k + 1;
            wait_idle();
            random_config(1'b0);
            k = $urandom_range(1, 8);
            repeat (k) send_req(1'b0);
            blit_items += k;
        end else begin
            send_req(1'b1);
            blit_items++;
            if (kind == 7 && n > 1) begin
                // abandon part way and start again
                k = $urandom_range(0, n - 2);
                repeat (k) send_req(1'b0);
                send_req(1'b1);
                blit_items += k + 1;
            end
            if (n > 1) begin
                repeat (n - 1) send_req(1'b0);
                blit_items += n - 1;
            end
            if (kind == 8)
                repeat ($urandom_range(1, 3)) send_req(1'b0);
        end
    endtask

    // receiver: random stall before each beat, or one long hold when asked
    initial begin : receiver
        int hold;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                hold    = rx_hold;
                rx_hold = 0;
            end else begin
                hold = $urandom_range(0, rx_gap_max);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid)
                @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int phase;
        phase = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still at reset: every size is zero, then a next while idle
        send_req(1'b1);
        send_req(1'b0);
        wait_idle();

        // plain 3x2 blit, plus one next past the last pixel
        set_rect(5, 7, 3, 2, 2, 3, 3, 2);
        send_req(1'b1);
        repeat (6) send_req(1'b0);
        wait_idle();

        // begin while busy restarts from the first pixel
        set_rect(0, 0, 4095, 1, 0, 0, 2, 2);
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        wait_idle();

        // negative offsets clipped down to the corner pixel
        set_rect(0, 0, 1, 1, -2, -1, 3, 2);
        send_req(1'b1);
        wait_idle();

        // largest sizes, clipped at the far corner
        set_rect(4095, 4095, 4095, 4095, 1022, 1023, 4095, 4095);
        send_req(1'b1);
        send_req(1'b0);
        wait_idle();

        // fully clipped off the right edge and off the left edge
        write_reg(REG_DST_LEFT, 1024);
        send_req(1'b1);
        wait_idle();
        write_reg(REG_DST_LEFT, -8192);
        send_req(1'b1);
        wait_idle();

        // zero source width
        write_reg(REG_DST_LEFT, 0);
        write_reg(REG_SRC_WIDTH, 0);
        send_req(1'b1);
        wait_idle();

        // registers moved mid-blit: negative distances truncate toward zero
        // and the source wraps below zero; then a cleared height abandons it
        set_rect(1, 0, 7, 3, 0, 0, 3, 3);
        send_req(1'b1);
        send_req(1'b0);
        wait_idle();
        write_reg(REG_DST_LEFT, 2);
        repeat (3) send_req(1'b0);
        wait_idle();
        write_reg(REG_DST_HEIGHT, 0);
        send_req(1'b0);
        send_req(1'b0);
        wait_idle();

        // back-pressure: receiver holds off while the sender keeps offering,
        // so the job queue fills and the request stream stalls
        set_rect($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(1, 4095),
                 $urandom_range(1, 4095), 100, 200, 48, 4);
        tx_gap_max = 0;
        rx_gap_max = 0;
        rx_hold    = LONG_HOLD;
        send_req(1'b1);
        repeat (191) send_req(1'b0);
        wait_idle();

        // random phases
        while (items_sent < REQ_ITEMS) begin
            wait_idle();
            tx_gap_max = pick_idle_max();
            rx_gap_max = pick_idle_max();
            random_config(phase == 0);
            run_blit_sequence();
            phase++;
        end

        wait_idle();
        $display("%0d requests (%0d in random blits) in %0d random phases, %0d register writes",
                 items_sent, blit_items, phase, config_writes);
        $display("one %0d-cycle output hold; %0d copy commands checked, %0d blits, %0d mismatch(es)",
                 LONG_HOLD, copies, blits, mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/nnsb_pkg.sv
rtl/nnsb_div.sv
rtl/nnsb_front.sv
rtl/nnsb_queue.sv
rtl/nnsb_back.sv
rtl/nearest_neighbor_scale_blit_addresses.sv
tb/nnsb_copy_checker.sv
tb/nearest_neighbor_scale_blit_addresses_test.sv
